>>> rtl/rfrf_pkg.sv
// rfrf_pkg: shared codes, constants and controller/datapath structs of the frame receive filter
// depends on nothing; used by every module under rtl
package rfrf_pkg;

	// input item kinds
	localparam logic [1:0] KIND_BYTE   = 2'd0;
	localparam logic [1:0] KIND_QUERY  = 2'd1;
	localparam logic [1:0] KIND_RESYNC = 2'd2;

	// result kinds
	localparam logic [1:0] REC_HDR     = 2'd0;
	localparam logic [1:0] REC_PAYLOAD = 2'd1;
	localparam logic [1:0] REC_LEN_ERR = 2'd2;
	localparam logic [1:0] REC_METRICS = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_OWN_ID     = 2'd0;
	localparam logic [1:0] CFG_NETWORK_ID = 2'd1;
	localparam logic [1:0] CFG_BCAST_ID   = 2'd2;
	localparam logic [1:0] CFG_DATA_TYPE  = 2'd3;

	localparam logic [7:0] HDR_BYTES = 8'd5;
	localparam logic [6:0] PCT_SCALE = 7'd100;
	localparam int         QUO_BITS  = 7;

	typedef struct packed {
		logic       take_item;   // byte or resync transaction accepted
		logic       mul_go;      // load product and total for the divider
		logic       div_step;    // one restoring division step
		logic [2:0] div_idx;     // quotient bit handled by this step
		logic       put_metrics; // load the metrics result
	} cmd_t;

	typedef struct packed {
		logic res_free; // result register empty or being taken
	} status_t;

endpackage

>>> rtl/rfrf_div.sv
// rfrf_div: packet error percentage unit, a multiply then seven restoring steps
// depends on rfrf_pkg
module rfrf_div (
	input  logic        clk,
	input  logic [31:0] ok_cnt,
	input  logic [31:0] miss_cnt,
	input  logic        mul_go,
	input  logic        div_step,
	input  logic [2:0]  div_idx,
	output logic [6:0]  pct
);

	logic [39:0] rem_q;
	logic [32:0] total_q;
	logic [6:0]  quo_q;
	logic [39:0] cand;

	// quotient never exceeds 100, so seven bits of shift cover it
	assign cand = 40'(total_q) << div_idx;

	always_ff @(posedge clk) begin
		if (mul_go) begin
			rem_q   <= 40'(miss_cnt) * 40'(rfrf_pkg::PCT_SCALE);
			total_q <= 33'(ok_cnt) + 33'(miss_cnt);
			quo_q   <= '0;
		end else if (div_step) begin
			if (total_q != '0 && rem_q >= cand) begin
				rem_q          <= rem_q - cand;
				quo_q[div_idx] <= 1'b1;
			end
		end
	end

	assign pct = quo_q;

endmodule

>>> rtl/rfrf_dp.sv
// rfrf_dp: frame parser, address filter, link counters, config registers and result register
// depends on rfrf_pkg and rfrf_div
module rfrf_dp #(
	parameter int MAX_BODY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rfrf_pkg::cmd_t    cmd,
	output rfrf_pkg::status_t status,
	input  logic [1:0]        kind,
	input  logic [7:0]        rx_byte,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              res_ready,
	output logic              res_valid,
	output logic [1:0]        rec_kind,
	output logic [7:0]        src_id,
	output logic [7:0]        dst_id,
	output logic [7:0]        frame_type,
	output logic [7:0]        seq_num,
	output logic [5:0]        pay_len,
	output logic [7:0]        data_byte,
	output logic              last,
	output logic [6:0]        per_pct,
	output logic [31:0]       ok_count,
	output logic [31:0]       missing_count
);

	localparam logic [7:0] MaxBodyB = 8'(MAX_BODY);

	logic [7:0]  own_id_q, network_id_q, bcast_id_q, data_type_q;
	logic [7:0]  pos_q, body_q, exp_seq_q;
	logic        acc_q, disc_q, exp_vld_q;
	logic [31:0] ok_q, miss_q;
	logic [7:0]  hdr_q [5];
	logic        res_valid_q;

	logic [7:0]  pos_d, body_d, exp_seq_d;
	logic        acc_d, disc_d, exp_vld_d;
	logic [31:0] ok_d, miss_d;
	logic        hdr_we;
	logic [2:0]  hdr_idx;
	logic        has_res, match, fin;
	logic [1:0]  r_kind;
	logic [7:0]  r_src, r_dst, r_type, r_seq, r_data;
	logic [5:0]  r_plen;
	logic        r_last;
	logic [6:0]  pct;

	rfrf_div u_div (
		.clk      (clk),
		.ok_cnt   (ok_q),
		.miss_cnt (miss_q),
		.mul_go   (cmd.mul_go),
		.div_step (cmd.div_step),
		.div_idx  (cmd.div_idx),
		.pct      (pct)
	);

	assign status.res_free = !res_valid_q || res_ready;

	always_comb begin
		pos_d     = pos_q;
		body_d    = body_q;
		acc_d     = acc_q;
		disc_d    = disc_q;
		exp_seq_d = exp_seq_q;
		exp_vld_d = exp_vld_q;
		ok_d      = ok_q;
		miss_d    = miss_q;
		hdr_we    = 1'b0;
		hdr_idx   = 3'(pos_q - 8'd1);
		has_res   = 1'b0;
		match     = 1'b0;
		fin       = 1'b0;
		r_kind    = rfrf_pkg::REC_HDR;
		r_src     = '0;
		r_dst     = '0;
		r_type    = '0;
		r_seq     = '0;
		r_data    = '0;
		r_plen    = '0;
		r_last    = 1'b0;
		if (kind == rfrf_pkg::KIND_RESYNC) begin
			disc_d = 1'b0;
			pos_d  = '0;
			acc_d  = 1'b0;
		end else if (kind == rfrf_pkg::KIND_BYTE && !disc_q) begin
			if (pos_q == '0) begin
				if (rx_byte < rfrf_pkg::HDR_BYTES || rx_byte > MaxBodyB) begin
					disc_d  = 1'b1;
					has_res = 1'b1;
					r_kind  = rfrf_pkg::REC_LEN_ERR;
				end else begin
					body_d = rx_byte;
					pos_d  = 8'd1;
					acc_d  = 1'b0;
				end
			end else if (pos_q <= rfrf_pkg::HDR_BYTES) begin
				hdr_we = 1'b1;
				if (pos_q < rfrf_pkg::HDR_BYTES) begin
					pos_d = pos_q + 8'd1;
				end else begin
					// last header byte is the sequence number, used straight from the input
					match = (hdr_q[0] == network_id_q) &&
						(hdr_q[2] == own_id_q || hdr_q[2] == bcast_id_q);
					acc_d = match;
					pos_d = (body_q == rfrf_pkg::HDR_BYTES) ? 8'd0 : pos_q + 8'd1;
					if (match) begin
						if (hdr_q[3] == data_type_q) begin
							if (exp_vld_q) begin
								miss_d = miss_q + 32'(8'(rx_byte - exp_seq_q));
							end
							exp_vld_d = 1'b1;
							exp_seq_d = rx_byte + 8'd1;
							ok_d      = ok_q + 32'd1;
						end
						has_res = 1'b1;
						r_kind  = rfrf_pkg::REC_HDR;
						r_src   = hdr_q[1];
						r_dst   = hdr_q[2];
						r_type  = hdr_q[3];
						r_seq   = rx_byte;
						r_plen  = 6'(body_q - rfrf_pkg::HDR_BYTES);
						r_last  = (body_q == rfrf_pkg::HDR_BYTES);
					end
				end
			end else begin
				fin   = (pos_q >= body_q);
				pos_d = fin ? 8'd0 : pos_q + 8'd1;
				if (acc_q) begin
					has_res = 1'b1;
					r_kind  = rfrf_pkg::REC_PAYLOAD;
					r_data  = rx_byte;
					r_last  = fin;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q     <= 8'd0;
			network_id_q <= 8'd0;
			bcast_id_q   <= 8'd255;
			data_type_q  <= 8'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rfrf_pkg::CFG_OWN_ID:     own_id_q     <= cfg_data;
				rfrf_pkg::CFG_NETWORK_ID: network_id_q <= cfg_data;
				rfrf_pkg::CFG_BCAST_ID:   bcast_id_q   <= cfg_data;
				rfrf_pkg::CFG_DATA_TYPE:  data_type_q  <= cfg_data;
				default:                  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			body_q    <= '0;
			acc_q     <= 1'b0;
			disc_q    <= 1'b0;
			exp_seq_q <= '0;
			exp_vld_q <= 1'b0;
			ok_q      <= '0;
			miss_q    <= '0;
		end else if (cmd.take_item) begin
			pos_q     <= pos_d;
			body_q    <= body_d;
			acc_q     <= acc_d;
			disc_q    <= disc_d;
			exp_seq_q <= exp_seq_d;
			exp_vld_q <= exp_vld_d;
			ok_q      <= ok_d;
			miss_q    <= miss_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item && hdr_we) begin
			hdr_q[hdr_idx] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((cmd.take_item && has_res) || cmd.put_metrics) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.put_metrics) begin
			rec_kind      <= rfrf_pkg::REC_METRICS;
			src_id        <= '0;
			dst_id        <= '0;
			frame_type    <= '0;
			seq_num       <= '0;
			pay_len       <= '0;
			data_byte     <= '0;
			last          <= 1'b0;
			per_pct       <= pct;
			ok_count      <= ok_q;
			missing_count <= miss_q;
		end else if (cmd.take_item && has_res) begin
			rec_kind      <= r_kind;
			src_id        <= r_src;
			dst_id        <= r_dst;
			frame_type    <= r_type;
			seq_num       <= r_seq;
			pay_len       <= r_plen;
			data_byte     <= r_data;
			last          <= r_last;
			per_pct       <= '0;
			ok_count      <= '0;
			missing_count <= '0;
		end
	end

	assign res_valid = res_valid_q;

endmodule

>>> rtl/rfrf_ctrl.sv
// rfrf_ctrl: controller state machine, input handshake and metrics sequencing
// depends on rfrf_pkg
module rfrf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  logic [1:0]        kind,
	input  rfrf_pkg::status_t status,
	output rfrf_pkg::cmd_t    cmd
);

	localparam logic [1:0] ST_RUN = 2'd0;
	localparam logic [1:0] ST_MUL = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_PUT = 2'd3;

	logic [1:0] state_q, state_d;
	logic [2:0] step_q, step_d;
	logic       take;

	assign item_ready = (state_q == ST_RUN) && status.res_free;
	assign take       = item_valid && item_ready;

	always_comb begin
		state_d         = state_q;
		step_d          = step_q;
		cmd.take_item   = 1'b0;
		cmd.mul_go      = 1'b0;
		cmd.div_step    = 1'b0;
		cmd.div_idx     = step_q;
		cmd.put_metrics = 1'b0;
		unique case (state_q)
			ST_RUN: begin
				if (take) begin
					if (kind == rfrf_pkg::KIND_QUERY) state_d = ST_MUL;
					else cmd.take_item = 1'b1;
				end
			end
			ST_MUL: begin
				cmd.mul_go = 1'b1;
				step_d     = 3'(rfrf_pkg::QUO_BITS - 1);
				state_d    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == '0) state_d = ST_PUT;
				else step_d = step_q - 3'd1;
			end
			ST_PUT: begin
				if (status.res_free) begin
					cmd.put_metrics = 1'b1;
					state_d         = ST_RUN;
				end
			end
			default: state_d = ST_RUN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	a_ready_only_run: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> state_q == ST_RUN)
		else $error("item_ready outside run state");

	a_query_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(take && kind == rfrf_pkg::KIND_QUERY) |=> state_q == ST_MUL)
		else $error("metrics query did not start the divider");

	a_last_step_puts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == '0) |=> state_q == ST_PUT)
		else $error("divider did not finish after the last step");

	a_no_take_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_go || cmd.div_step) |-> !cmd.take_item && !cmd.put_metrics)
		else $error("item taken while divider busy");

endmodule

>>> rtl/radio_frame_receive_filter.sv
// radio_frame_receive_filter: top level, length-prefixed deframer with address filter and metrics
// depends on rfrf_pkg, rfrf_ctrl, rfrf_dp (which holds rfrf_div)
//
// channel  | handshake              | payload
// item     | item_valid, item_ready | kind, rx_byte
// result   | res_valid, res_ready   | rec_kind .. missing_count
// config   | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// byte and resync transactions go straight to the datapath; bytes stream back to back while results drain
// a metrics query runs accept, multiply, seven restoring divider steps, then result load
// the percentage divider in rfrf_div sets the query length; nothing else iterates
// asynchronous reset; no clearing pass, header store is written before it is read
// a held result stalls the item channel until res_ready takes it; config is always ready
module radio_frame_receive_filter #(
	parameter int MAX_BODY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  rx_byte,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  rec_kind,
	output logic [7:0]  src_id,
	output logic [7:0]  dst_id,
	output logic [7:0]  frame_type,
	output logic [7:0]  seq_num,
	output logic [5:0]  pay_len,
	output logic [7:0]  data_byte,
	output logic        last,
	output logic [6:0]  per_pct,
	output logic [31:0] ok_count,
	output logic [31:0] missing_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	rfrf_pkg::cmd_t    cmd;
	rfrf_pkg::status_t status;

	assign cfg_ready = 1'b1;

	rfrf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.kind       (kind),
		.status     (status),
		.cmd        (cmd)
	);

	rfrf_dp #(
		.MAX_BODY (MAX_BODY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.kind          (kind),
		.rx_byte       (rx_byte),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.res_ready     (res_ready),
		.res_valid     (res_valid),
		.rec_kind      (rec_kind),
		.src_id        (src_id),
		.dst_id        (dst_id),
		.frame_type    (frame_type),
		.seq_num       (seq_num),
		.pay_len       (pay_len),
		.data_byte     (data_byte),
		.last          (last),
		.per_pct       (per_pct),
		.ok_count      (ok_count),
		.missing_count (missing_count)
	);

endmodule

>>> verif/tb_radio_frame_receive_filter.sv
// tb_radio_frame_receive_filter: self-checking testbench for the frame receive filter
// depends on rfrf_pkg and radio_frame_receive_filter; a scoreboard class predicts every result
// directed frames first, then random frames, queries, resyncs and noise over four register settings
`timescale 1ns / 100ps

module tb_radio_frame_receive_filter;

	localparam int          MAX_BODY     = 64;
	localparam logic [1:0]  KIND_UNUSED  = 2'd3;
	localparam int          IDLE_LIMIT   = 2000;
	localparam int          HOLD_CYCLES  = 200;
	localparam int          PHASE_ITEMS  = 150;
	localparam int          PRINT_LIMIT  = 40;

	typedef struct packed {
		logic [1:0]  rec_kind;
		logic [7:0]  src_id;
		logic [7:0]  dst_id;
		logic [7:0]  frame_type;
		logic [7:0]  seq_num;
		logic [5:0]  pay_len;
		logic [7:0]  data_byte;
		logic        last;
		logic [6:0]  per_pct;
		logic [31:0] ok_count;
		logic [31:0] missing_count;
	} frame_result_t;

	// predicts the deframer output and holds the results still owed by the block
	class frame_filter_scoreboard;
		bit [7:0]      own_id, network_id, broadcast_id, data_type_code;
		bit [7:0]      byte_pos, frame_len;
		bit [7:0]      hdr [5];
		bit            accepted, discarding;
		bit [7:0]      next_seq;
		bit            next_seq_valid;
		bit [31:0]     ok_cnt, missing_cnt;
		frame_result_t expected_q[$];
		int            fail_count, items_seen;
		int            hdr_seen, payload_seen, len_err_seen, metrics_seen;

		function new();
			own_id         = 8'h00;
			network_id     = 8'h00;
			broadcast_id   = 8'hFF;
			data_type_code = 8'h01;
			byte_pos       = '0;
			frame_len      = '0;
			foreach (hdr[i]) hdr[i] = '0;
			accepted       = 1'b0;
			discarding     = 1'b0;
			next_seq       = '0;
			next_seq_valid = 1'b0;
			ok_cnt         = '0;
			missing_cnt    = '0;
		endfunction

		function void report_mismatch(string msg);
			fail_count++;
			if (fail_count <= PRINT_LIMIT)
				$display("%0t mismatch: %s", $realtime, msg);
		endfunction

		function void write_reg(logic [1:0] idx, logic [7:0] v);
			case (idx)
				rfrf_pkg::CFG_OWN_ID:     own_id = v;
				rfrf_pkg::CFG_NETWORK_ID: network_id = v;
				rfrf_pkg::CFG_BCAST_ID:   broadcast_id = v;
				rfrf_pkg::CFG_DATA_TYPE:  data_type_code = v;
				default: ;
			endcase
		endfunction

		function void count_data_frame(bit [7:0] seq);
			if (next_seq_valid)
				missing_cnt += 32'(8'(seq - next_seq));
			next_seq_valid = 1'b1;
			next_seq = seq + 8'd1;
			ok_cnt += 32'd1;
		endfunction

		function void note_item(logic [1:0] k, logic [7:0] b);
			frame_result_t    r;
			longint unsigned  total;
			bit               final_byte;
			r = '0;
			items_seen++;
			if (k == rfrf_pkg::KIND_QUERY) begin
				total = longint'(ok_cnt) + longint'(missing_cnt);
				r.rec_kind = rfrf_pkg::REC_METRICS;
				if (total != 0)
					r.per_pct = 7'((longint'(missing_cnt) * 100) / total);
				r.ok_count = ok_cnt;
				r.missing_count = missing_cnt;
				expected_q.push_back(r);
				return;
			end
			if (k == rfrf_pkg::KIND_RESYNC) begin
				discarding = 1'b0;
				byte_pos = '0;
				accepted = 1'b0;
				return;
			end
			if (k == KIND_UNUSED || discarding)
				return;
			if (byte_pos == 0) begin
				if (b < rfrf_pkg::HDR_BYTES || int'(b) > MAX_BODY) begin
					discarding = 1'b1;
					r.rec_kind = rfrf_pkg::REC_LEN_ERR;
					expected_q.push_back(r);
					return;
				end
				frame_len = b;
				byte_pos = 8'd1;
				accepted = 1'b0;
				return;
			end
			if (byte_pos <= rfrf_pkg::HDR_BYTES) begin
				hdr[byte_pos - 1] = b;
				if (byte_pos < rfrf_pkg::HDR_BYTES) begin
					byte_pos++;
					return;
				end
				accepted = (hdr[0] == network_id) &&
					(hdr[2] == own_id || hdr[2] == broadcast_id);
				if (frame_len == rfrf_pkg::HDR_BYTES)
					byte_pos = '0;
				else
					byte_pos++;
				if (!accepted)
					return;
				if (hdr[3] == data_type_code)
					count_data_frame(hdr[4]);
				r.rec_kind = rfrf_pkg::REC_HDR;
				r.src_id = hdr[1];
				r.dst_id = hdr[2];
				r.frame_type = hdr[3];
				r.seq_num = hdr[4];
				r.pay_len = 6'(frame_len - rfrf_pkg::HDR_BYTES);
				r.last = (frame_len == rfrf_pkg::HDR_BYTES);
				expected_q.push_back(r);
				return;
			end
			// payload byte
			final_byte = (byte_pos >= frame_len);
			if (final_byte)
				byte_pos = '0;
			else
				byte_pos++;
			if (!accepted)
				return;
			r.rec_kind = rfrf_pkg::REC_PAYLOAD;
			r.data_byte = b;
			r.last = final_byte;
			expected_q.push_back(r);
		endfunction

		function void cmp_field(string name, longint unsigned got, longint unsigned want);
			if (got != want)
				report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result, rec_kind %0d", got.rec_kind));
				return;
			end
			want = expected_q.pop_front();
			case (want.rec_kind)
				rfrf_pkg::REC_HDR:     hdr_seen++;
				rfrf_pkg::REC_PAYLOAD: payload_seen++;
				rfrf_pkg::REC_LEN_ERR: len_err_seen++;
				default:               metrics_seen++;
			endcase
			cmp_field("rec_kind", got.rec_kind, want.rec_kind);
			cmp_field("src_id", got.src_id, want.src_id);
			cmp_field("dst_id", got.dst_id, want.dst_id);
			cmp_field("frame_type", got.frame_type, want.frame_type);
			cmp_field("seq_num", got.seq_num, want.seq_num);
			cmp_field("pay_len", got.pay_len, want.pay_len);
			cmp_field("data_byte", got.data_byte, want.data_byte);
			cmp_field("last", got.last, want.last);
			cmp_field("per_pct", got.per_pct, want.per_pct);
			cmp_field("ok_count", got.ok_count, want.ok_count);
			cmp_field("missing_count", got.missing_count, want.missing_count);
		endfunction
	endclass

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        item_valid  = 1'b0;
	logic        item_ready;
	logic [1:0]  kind        = rfrf_pkg::KIND_BYTE;
	logic [7:0]  rx_byte     = 8'h00;
	logic        res_valid;
	logic        res_ready   = 1'b0;
	logic [1:0]  rec_kind;
	logic [7:0]  src_id, dst_id, frame_type, seq_num;
	logic [5:0]  pay_len;
	logic [7:0]  data_byte;
	logic        last;
	logic [6:0]  per_pct;
	logic [31:0] ok_count, missing_count;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index   = rfrf_pkg::CFG_OWN_ID;
	logic [7:0]  cfg_data    = 8'h00;

	frame_filter_scoreboard sb = new();
	frame_result_t          seen_result;
	bit                     gaps_on = 1'b1;
	bit                     hold_request = 1'b0;
	int                     holds_done = 0;
	int                     useful_items = 0;
	bit [7:0]               seq_hint = 8'h00;

	radio_frame_receive_filter #(.MAX_BODY(MAX_BODY)) dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .kind(kind), .rx_byte(rx_byte),
		.res_valid(res_valid), .res_ready(res_ready), .rec_kind(rec_kind),
		.src_id(src_id), .dst_id(dst_id), .frame_type(frame_type), .seq_num(seq_num),
		.pay_len(pay_len), .data_byte(data_byte), .last(last), .per_pct(per_pct),
		.ok_count(ok_count), .missing_count(missing_count),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// one sampling point per edge: config, then input, then result
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (item_valid && item_ready)
				sb.note_item(kind, rx_byte);
			if (res_valid && res_ready) begin
				seen_result.rec_kind = rec_kind;
				seen_result.src_id = src_id;
				seen_result.dst_id = dst_id;
				seen_result.frame_type = frame_type;
				seen_result.seq_num = seq_num;
				seen_result.pay_len = pay_len;
				seen_result.data_byte = data_byte;
				seen_result.last = last;
				seen_result.per_pct = per_pct;
				seen_result.ok_count = ok_count;
				seen_result.missing_count = missing_count;
				sb.check_result(seen_result);
			end
		end
	end

	// result side: random back-pressure plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_request) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
				holds_done++;
			end
			res_ready <= gaps_on ? ($urandom_range(99) >= 12) : 1'b1;
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (res_valid && res_ready) ||
			    (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
		$display("[radio_frame_receive_filter] ERROR");
		$finish;
	end

	// valid stays high between back-to-back items; lowered only by a gap or the caller
	task automatic send_item(logic [1:0] k, logic [7:0] b, bit useful);
		if (gaps_on && $urandom_range(99) < 12) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		kind <= k;
		rx_byte <= b;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		if (useful)
			useful_items++;
	endtask

	// frame byte, sometimes preceded by a metrics query in the middle of the frame
	task automatic send_frame_byte(logic [7:0] b);
		if ($urandom_range(99) < 3)
			send_item(rfrf_pkg::KIND_QUERY, 8'($urandom), 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, b, 1'b1);
	endtask

	task automatic send_frame();
		int       len, r;
		bit [7:0] net, dst, ftype, seq;
		r = $urandom_range(99);
		if (r < 65)
			len = $urandom_range(5, 10);
		else if (r < 85)
			len = $urandom_range(11, 24);
		else if (r < 93)
			len = MAX_BODY;
		else
			len = $urandom_range(5, MAX_BODY);
		net = ($urandom_range(99) < 88) ? sb.network_id : 8'($urandom);
		r = $urandom_range(99);
		dst = (r < 45) ? sb.own_id : (r < 80) ? sb.broadcast_id : 8'($urandom);
		ftype = ($urandom_range(99) < 70) ? sb.data_type_code : 8'($urandom);
		r = $urandom_range(99);
		seq = (r < 55) ? seq_hint : (r < 85) ? seq_hint + 8'($urandom_range(1, 4)) :
			8'($urandom);
		seq_hint = seq + 8'd1;
		send_frame_byte(8'(len));
		send_frame_byte(net);
		send_frame_byte(8'($urandom));
		send_frame_byte(dst);
		send_frame_byte(ftype);
		send_frame_byte(seq);
		for (int i = 0; i < len - 5; i++)
			send_frame_byte(8'($urandom));
	endtask

	task automatic send_random(int target);
		int stop_at, r, n;
		stop_at = useful_items + target;
		while (useful_items < stop_at) begin
			r = $urandom_range(99);
			if (r < 76)
				send_frame();
			else if (r < 84)
				send_item(rfrf_pkg::KIND_QUERY, 8'($urandom), 1'b1);
			else if (r < 87)
				send_item(rfrf_pkg::KIND_RESYNC, 8'($urandom), 1'b1);
			else if (r < 93) begin
				// bad length, some dropped bytes, then recovery
				if ($urandom_range(1))
					send_item(rfrf_pkg::KIND_BYTE, 8'($urandom_range(0, 4)), 1'b1);
				else
					send_item(rfrf_pkg::KIND_BYTE, 8'($urandom_range(MAX_BODY + 1, 255)),
						1'b1);
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++)
					send_item(rfrf_pkg::KIND_BYTE, 8'($urandom), 1'b0);
				send_item(rfrf_pkg::KIND_RESYNC, 8'($urandom), 1'b1);
			end else if (r < 96)
				send_item(KIND_UNUSED, 8'($urandom), 1'b0);
			else begin
				// frame abandoned by a resync part way through
				send_item(rfrf_pkg::KIND_BYTE, 8'($urandom_range(6, MAX_BODY)), 1'b1);
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					send_item(rfrf_pkg::KIND_BYTE, 8'($urandom), 1'b1);
				send_item(rfrf_pkg::KIND_RESYNC, 8'($urandom), 1'b1);
			end
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic program_regs(logic [7:0] lid, logic [7:0] nid, logic [7:0] bid,
		logic [7:0] dtype);
		write_reg(rfrf_pkg::CFG_OWN_ID, lid);
		write_reg(rfrf_pkg::CFG_NETWORK_ID, nid);
		write_reg(rfrf_pkg::CFG_BCAST_ID, bid);
		write_reg(rfrf_pkg::CFG_DATA_TYPE, dtype);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// drain all owed results, then give a query in flight time to finish
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// setting 1: directed checks, then random traffic
		program_regs(8'h12, 8'h00, 8'hFF, 8'h01);
		send_item(rfrf_pkg::KIND_QUERY, 8'h00, 1'b1);   // no frames yet, percentage zero
		send_item(rfrf_pkg::KIND_BYTE, 8'd4, 1'b1);     // length too short
		send_item(rfrf_pkg::KIND_BYTE, 8'h55, 1'b0);    // dropped while discarding
		send_item(rfrf_pkg::KIND_RESYNC, 8'hFF, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'd65, 1'b1);    // length too long
		send_item(rfrf_pkg::KIND_RESYNC, 8'h00, 1'b1);
		// empty payload to own id, sequence wraps
		send_item(rfrf_pkg::KIND_BYTE, 8'd5, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h00, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'hA5, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h12, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h01, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'hFF, 1'b1);
		// broadcast frame with a query in the header, sequence gap of three
		send_item(rfrf_pkg::KIND_BYTE, 8'd6, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h00, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h00, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'hFF, 1'b1);
		send_item(rfrf_pkg::KIND_QUERY, 8'hFF, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h01, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h03, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'hFF, 1'b1);
		// wrong destination, consumed silently
		send_item(rfrf_pkg::KIND_BYTE, 8'd5, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h00, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h5A, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h34, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h01, 1'b1);
		send_item(rfrf_pkg::KIND_BYTE, 8'h09, 1'b1);
		send_item(KIND_UNUSED, 8'hAA, 1'b0);
		seq_hint = 8'h04;
		send_random(PHASE_ITEMS - 25);
		wait_drained();

		// setting 2: all-ones own id, network id and data type, broadcast id zero; long hold-off
		program_regs(8'hFF, 8'hFF, 8'h00, 8'hFF);
		hold_request = 1'b1;
		send_random(PHASE_ITEMS);
		wait_drained();

		// setting 3: no idling on either side
		gaps_on = 1'b0;
		program_regs(8'h00, 8'($urandom), 8'($urandom), 8'h00);
		send_random(PHASE_ITEMS);
		wait_drained();

		// setting 4: random ids
		gaps_on = 1'b1;
		program_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		send_random(PHASE_ITEMS);
		wait_drained();
		repeat (20) @(posedge clk);

		if (sb.expected_q.size() != 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
		$display("covered %0d input transactions over 4 register settings, %0d long hold-off",
			sb.items_seen, holds_done);
		$display("results: %0d headers, %0d payload bytes, %0d length errors, %0d metrics",
			sb.hdr_seen, sb.payload_seen, sb.len_err_seen, sb.metrics_seen);
		if (sb.fail_count == 0)
			$display("[radio_frame_receive_filter] OK");
		else
			$display("[radio_frame_receive_filter] ERROR");
		$finish;
	end

endmodule
